/* rtl/preset_kernel_3x3_convolution_defines.svh */
// Assertion shorthands shared by the RTL; they expect clk and arst_n in scope.
`ifndef PRESET_KERNEL_3X3_CONVOLUTION_DEFINES_SVH
`define PRESET_KERNEL_3X3_CONVOLUTION_DEFINES_SVH

// property must hold at every edge outside reset
`define PK3C_ASSERT_HOLD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define PK3C_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pk3c_pkg.sv */
package pk3c_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;

	typedef enum logic [1:0] {
		REG_FILTER_KIND,
		REG_MAX_VALUE,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} reg_index_t;

	typedef enum logic [2:0] {
		KIND_SMOOTH,
		KIND_BLUR,
		KIND_SHARPEN,
		KIND_MEAN_REMOVAL,
		KIND_EMBOSS
	} kind_t;

	typedef struct packed {
		logic        command;
		logic [15:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic        last_pixel;
	} out_word_t;

	typedef struct packed {
		logic valid;
		logic last;
	} tap_ctl_t;

	// unknown kinds fall back to smooth
	function automatic logic [4:0] kernel_div(input logic [2:0] kind);
		logic [4:0] d;
		case (kind_t'(kind))
			KIND_BLUR:         d = 5'd16;
			KIND_SHARPEN:      d = 5'd3;
			KIND_MEAN_REMOVAL: d = 5'd1;
			KIND_EMBOSS:       d = 5'd1;
			default:           d = 5'd9;
		endcase
		return d;
	endfunction

	function automatic logic [6:0] kernel_off(input logic [2:0] kind);
		logic [6:0] o;
		case (kind_t'(kind))
			KIND_EMBOSS: o = 7'd127;
			default:     o = 7'd0;
		endcase
		return o;
	endfunction

endpackage

/* rtl/preset_kernel_3x3_convolution.sv */
// 3x3 convolution over a row-major grey stream with five preset kernels (smooth, blur,
// sharpen, mean removal, emboss), zero outside the image, truncating divide, offset and
// clamp to 0..max_value. One word is taken per clock while in_stall is low; the two previous
// rows sit in one line memory (one read port at the incoming column, one write port at the
// column of the word before it), and when successive words hit the same column the pending
// write data is forwarded. The result for pixel (r,c) comes out once word (r+1)*width+c+1
// has been taken, so append width+1 flush words after the image; it then passes stage 1,
// arithmetic stages s2 to s7 and the output register to out_data. The line memory is not
// cleared after reset: rows above the top are masked by the row counter instead. Write
// configuration only between images, with nothing in flight; a write takes effect at once.
`include "preset_kernel_3x3_convolution_defines.svh"

module preset_kernel_3x3_convolution #(
	parameter int MAX_WIDTH  = pk3c_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = pk3c_pkg::PIXEL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pk3c_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pk3c_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > 11) ? WW : 11;
	localparam int RW = 17;
	localparam int LW = 2 * PIXEL_BITS;

	logic [2:0]  kind_q;
	logic [15:0] max_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [EW-1:0] w_eff, width_ext, c_next;
	logic          wrap, cz, rge1, rge2, last_now, emit_now, in_acc, rdy1;
	logic [PIXEL_BITS-1:0] pix_now;

	logic                  v1_q;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         addr_s1;
	logic                  cz_s1, rge1_s1, rge2_s1, last_s1, emit_s1, fwd_s1;
	logic [LW-1:0]         fwd_data_s1;

	logic                  wr_en;
	logic [LW-1:0]         wr_data, rd_data, line_s1;
	logic [PIXEL_BITS-1:0] up_raw, mid_raw, nc0, nc1;
	logic [PIXEL_BITS-1:0] win_q [6];
	logic [PIXEL_BITS-1:0] taps [9];

	pk3c_pkg::tap_ctl_t tap_ctl;
	logic               tap_ready;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= 3'd0;
			max_q    <= 16'd255;
			width_q  <= 11'd640;
			height_q <= 16'd480;
		end else if (cfg_valid && cfg_ready) begin
			case (pk3c_pkg::reg_index_t'(cfg_index))
				pk3c_pkg::REG_FILTER_KIND:  kind_q   <= cfg_data[2:0];
				pk3c_pkg::REG_MAX_VALUE:    max_q    <= cfg_data;
				pk3c_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[10:0];
				pk3c_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position of the incoming word
	assign width_ext = EW'(width_q);
	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = width_ext;
		end
	end

	assign c_next   = EW'(col_q) + EW'(1);
	assign wrap     = c_next >= w_eff;
	assign cz       = col_q == '0;
	assign rge1     = row_q != '0;
	assign rge2     = row_q >= RW'(2);
	assign last_now = cz && rge2 && (height_q != '0) && (row_q == RW'(height_q) + RW'(1));
	assign emit_now = cz ? rge2 : rge1;
	assign pix_now  = in_data.command ? '0 : in_data.pixel_in[PIXEL_BITS-1:0];

	assign rdy1     = !v1_q || tap_ready;
	assign in_stall = !rdy1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_now) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= c_next[CW-1:0];
			end
		end
	end

	// stage 1: line memory read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (rdy1) begin
			v1_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= pix_now;
			addr_s1     <= col_q;
			cz_s1       <= cz;
			rge1_s1     <= rge1;
			rge2_s1     <= rge2;
			last_s1     <= last_now;
			emit_s1     <= emit_now;
			fwd_s1      <= wr_en && (addr_s1 == col_q);
			fwd_data_s1 <= wr_data;
		end
	end

	pk3c_line_mem #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (LW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	// entry holds {row two above, row one above}
	assign line_s1 = fwd_s1 ? fwd_data_s1 : rd_data;
	assign up_raw  = line_s1[LW-1:PIXEL_BITS];
	assign mid_raw = line_s1[PIXEL_BITS-1:0];
	assign nc0     = rge2_s1 ? up_raw : '0;
	assign nc1     = rge1_s1 ? mid_raw : '0;

	assign wr_en   = v1_q && tap_ready;
	assign wr_data = {mid_raw, pix_s1};

	// window: left column 0..2, middle column 3..5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (wr_en) begin
			win_q[0] <= cz_s1 ? '0 : win_q[3];
			win_q[1] <= cz_s1 ? '0 : win_q[4];
			win_q[2] <= cz_s1 ? '0 : win_q[5];
			win_q[3] <= nc0;
			win_q[4] <= nc1;
			win_q[5] <= pix_s1;
		end
	end

	// column zero closes the previous row: right column lies outside
	assign taps[0] = win_q[0];
	assign taps[1] = win_q[3];
	assign taps[2] = cz_s1 ? '0 : nc0;
	assign taps[3] = win_q[1];
	assign taps[4] = win_q[4];
	assign taps[5] = cz_s1 ? '0 : nc1;
	assign taps[6] = win_q[2];
	assign taps[7] = win_q[5];
	assign taps[8] = cz_s1 ? '0 : pix_s1;

	assign tap_ctl.valid = v1_q && emit_s1;
	assign tap_ctl.last  = last_s1;

	pk3c_arith #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind_q),
		.max_value (max_q),
		.tap_ctl   (tap_ctl),
		.taps      (taps),
		.tap_ready (tap_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`PK3C_ASSERT_NEXT(a_last_restarts, in_acc && last_now, col_q == '0 && row_q == '0, "counters not cleared after last pixel")
	`PK3C_ASSERT_NEXT(a_left_cleared, wr_en && cz_s1, win_q[0] == '0 && win_q[1] == '0 && win_q[2] == '0, "left column not cleared at row start")
	`PK3C_ASSERT_HOLD(a_fwd_col_zero, v1_q && fwd_s1 |-> cz_s1, "forwarding on a column other than zero")

endmodule

/* rtl/pk3c_line_mem.sv */
module pk3c_line_mem #(
	parameter int DEPTH = pk3c_pkg::MAX_WIDTH_DEF,
	parameter int WIDTH = 2 * pk3c_pkg::PIXEL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// read returns the old word on a same-address write; the caller forwards
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/pk3c_arith.sv */
`include "preset_kernel_3x3_convolution_defines.svh"

module pk3c_arith #(
	parameter int PIXEL_BITS = pk3c_pkg::PIXEL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [2:0]             kind,
	input  logic [15:0]            max_value,
	input  pk3c_pkg::tap_ctl_t     tap_ctl,
	input  logic [PIXEL_BITS-1:0]  taps [9],
	output logic                   tap_ready,
	output logic                   out_valid,
	input  logic                   out_stall,
	output pk3c_pkg::out_word_t    out_data
);

	localparam int SW  = PIXEL_BITS + 2;      // sum of four pixels
	localparam int AW  = PIXEL_BITS + 5;      // signed weighted sum
	localparam int K   = PIXEL_BITS + 4;      // magnitude bits
	localparam int VW  = K + 2;               // signed result after offset
	localparam int CMW = (VW > 16) ? VW + 1 : 17;
	localparam int unsigned R9  = (2 ** K) / 9;
	localparam int unsigned R16 = (2 ** K) / 16;
	localparam int unsigned R3  = (2 ** K) / 3;
	localparam int unsigned R1  = 2 ** K;

	logic v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;
	logic rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy_o;

	logic [PIXEL_BITS-1:0] taps_s2 [9];
	logic                  last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic [SW-1:0]         corner_s3, edge_s3;
	logic [PIXEL_BITS-1:0] center_s3;
	logic signed [AW-1:0]  acc_s4;
	logic                  neg_s5, neg_s6;
	logic [K-1:0]          abs_s5, abs_s6;
	logic [2*K:0]          prod_s6;
	logic signed [VW-1:0]  val_s7;
	pk3c_pkg::out_word_t   out_q;

	logic signed [AW-1:0] cs, es, xs, acc_next;
	logic [K:0]           recip;
	logic [4:0]           dv;
	logic [K-1:0]         q0, rem, q;
	logic [K+4:0]         qd;
	logic signed [VW-1:0] qs, val_next;
	logic [CMW-1:0]       val_ext, max_ext;
	logic [15:0]          clamped;

	assign rdy_o = !vo_q || !out_stall;
	assign rdy7  = !v7_q || rdy_o;
	assign rdy6  = !v6_q || rdy7;
	assign rdy5  = !v5_q || rdy6;
	assign rdy4  = !v4_q || rdy5;
	assign rdy3  = !v3_q || rdy4;
	assign rdy2  = !v2_q || rdy3;
	assign tap_ready = rdy2;

	// weighted sum: each kernel weights all corners alike, all edges alike, and the center
	assign cs = $signed(AW'(corner_s3));
	assign es = $signed(AW'(edge_s3));
	assign xs = $signed(AW'(center_s3));

	always_comb begin
		case (pk3c_pkg::kind_t'(kind))
			pk3c_pkg::KIND_BLUR:         acc_next = cs + (es <<< 1) + (xs <<< 2);
			pk3c_pkg::KIND_SHARPEN:      acc_next = (xs <<< 3) + (xs <<< 1) + xs - (es <<< 1);
			pk3c_pkg::KIND_MEAN_REMOVAL: acc_next = (xs <<< 3) + xs - cs - es;
			pk3c_pkg::KIND_EMBOSS:       acc_next = (xs <<< 2) - cs;
			default:                     acc_next = cs + es + xs;
		endcase
	end

	always_comb begin
		case (pk3c_pkg::kind_t'(kind))
			pk3c_pkg::KIND_BLUR:         recip = (K+1)'(R16);
			pk3c_pkg::KIND_SHARPEN:      recip = (K+1)'(R3);
			pk3c_pkg::KIND_MEAN_REMOVAL: recip = (K+1)'(R1);
			pk3c_pkg::KIND_EMBOSS:       recip = (K+1)'(R1);
			default:                     recip = (K+1)'(R9);
		endcase
	end

	// reciprocal estimate is low by at most one
	assign dv       = pk3c_pkg::kernel_div(kind);
	assign q0       = prod_s6[2*K-1:K];
	assign qd       = (K+5)'(q0) * (K+5)'(dv);
	assign rem      = abs_s6 - qd[K-1:0];
	assign q        = (rem >= K'(dv)) ? q0 + K'(1) : q0;
	assign qs       = $signed(VW'(q));
	assign val_next = (neg_s6 ? -qs : qs) + $signed(VW'(pk3c_pkg::kernel_off(kind)));

	assign val_ext = CMW'(val_s7[VW-2:0]);
	assign max_ext = CMW'(max_value);
	always_comb begin
		if (val_s7 < 0) begin
			clamped = '0;
		end else if (val_ext > max_ext) begin
			clamped = max_value;
		end else begin
			clamped = val_ext[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
			v7_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy2)  v2_q <= tap_ctl.valid;
			if (rdy3)  v3_q <= v2_q;
			if (rdy4)  v4_q <= v3_q;
			if (rdy5)  v5_q <= v4_q;
			if (rdy6)  v6_q <= v5_q;
			if (rdy7)  v7_q <= v6_q;
			if (rdy_o) vo_q <= v7_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && tap_ctl.valid) begin
			taps_s2 <= taps;
			last_s2 <= tap_ctl.last;
		end
		if (rdy3 && v2_q) begin
			corner_s3 <= SW'(taps_s2[0]) + SW'(taps_s2[2]) + SW'(taps_s2[6]) + SW'(taps_s2[8]);
			edge_s3   <= SW'(taps_s2[1]) + SW'(taps_s2[3]) + SW'(taps_s2[5]) + SW'(taps_s2[7]);
			center_s3 <= taps_s2[4];
			last_s3   <= last_s2;
		end
		if (rdy4 && v3_q) begin
			acc_s4  <= acc_next;
			last_s4 <= last_s3;
		end
		if (rdy5 && v4_q) begin
			neg_s5  <= acc_s4 < 0;
			abs_s5  <= (acc_s4 < 0) ? K'(-acc_s4) : K'(acc_s4);
			last_s5 <= last_s4;
		end
		if (rdy6 && v5_q) begin
			prod_s6 <= (2*K+1)'(abs_s5) * (2*K+1)'(recip);
			abs_s6  <= abs_s5;
			neg_s6  <= neg_s5;
			last_s6 <= last_s5;
		end
		if (rdy7 && v6_q) begin
			val_s7  <= val_next;
			last_s7 <= last_s6;
		end
		if (rdy_o && v7_q) begin
			out_q.pixel_out  <= clamped;
			out_q.last_pixel <= last_s7;
		end
	end

	assign out_valid = vo_q;
	assign out_data  = out_q;

	`PK3C_ASSERT_HOLD(a_out_clamped, out_valid |-> out_data.pixel_out <= max_value, "pixel above clamp")

endmodule

/* sim/tb.sv */
module tb;
	import pk3c_pkg::*;

	localparam int LINE_MAX      = MAX_WIDTH_DEF;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_word_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	preset_kernel_3x3_convolution uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// mirror of the block's registers, reset values
	logic [2:0]  mode_kind   = 3'd0;
	logic [15:0] mode_max    = 16'd255;
	logic [10:0] mode_width  = 11'd640;
	logic [15:0] mode_height = 16'd480;

	// filter state
	logic [15:0] upper_row  [0:LINE_MAX-1];
	logic [15:0] middle_row [0:LINE_MAX-1];
	logic [15:0] window_px  [0:5] = '{default: '0};
	int          col_pos = 0;
	logic [16:0] row_pos = '0;

	in_word_t    pixel_queue[$];
	out_word_t   expected_pixels[$];
	int          words_queued = 0;
	int          words_taken  = 0;
	int          mismatches   = 0;
	int          quiet_cycles = 0;
	logic        in_fire      = 1'b0;
	logic        cfg_fire     = 1'b0;
	logic        no_idle      = 1'b0;
	logic        hold_arm     = 1'b0;
	int          hold_left    = 0;
	logic        hold_done    = 1'b0;

	function automatic int line_len(input logic [10:0] w);
		if (w == 0)
			return 1;
		if (w > LINE_MAX)
			return LINE_MAX;
		return int'(w);
	endfunction

	// kernels are symmetric: one weight for corners, one for edges, one for the centre
	function automatic logic [15:0] filter_pixel(input int corners, input int edges,
			input int centre);
		int wc, we, wm, divisor, acc;
		wc = 1;
		we = 1;
		wm = 1;
		divisor = 9;
		case (mode_kind)
			KIND_BLUR: begin
				we = 2;
				wm = 4;
				divisor = 16;
			end
			KIND_SHARPEN: begin
				wc = 0;
				we = -2;
				wm = 11;
				divisor = 3;
			end
			KIND_MEAN_REMOVAL: begin
				wc = -1;
				we = -1;
				wm = 9;
				divisor = 1;
			end
			KIND_EMBOSS: begin
				wc = -1;
				we = 0;
				wm = 4;
				divisor = 1;
			end
			default: ;
		endcase
		acc = (wc * corners + we * edges + wm * centre) / divisor;
		if (mode_kind == KIND_EMBOSS)
			acc = acc + 127;
		if (acc < 0)
			return 16'h0000;
		if (acc > int'(mode_max))
			return mode_max;
		return acc[15:0];
	endfunction

	task automatic absorb_word(input in_word_t w);
		int          len, corners, edges;
		logic [15:0] pix, top, mid_row;
		logic        last_flag;
		out_word_t   res;
		len = line_len(mode_width);
		pix = w.command ? 16'h0000 : w.pixel_in;
		top = (row_pos >= 2) ? upper_row[col_pos] : 16'h0000;
		mid_row = (row_pos >= 1) ? middle_row[col_pos] : 16'h0000;
		upper_row[col_pos] = middle_row[col_pos];
		middle_row[col_pos] = pix;
		last_flag = 1'b0;
		if (col_pos == 0) begin
			// right column lies outside the image
			if (row_pos >= 2) begin
				last_flag = (mode_height != 0) && (int'(row_pos) - 2 == int'(mode_height) - 1);
				corners = int'(window_px[0]) + int'(window_px[2]);
				edges = int'(window_px[1]) + int'(window_px[3]) + int'(window_px[5]);
				res.pixel_out = filter_pixel(corners, edges, int'(window_px[4]));
				res.last_pixel = last_flag;
				expected_pixels.push_back(res);
			end
			window_px[0] = '0;
			window_px[1] = '0;
			window_px[2] = '0;
		end else begin
			if (row_pos >= 1) begin
				corners = int'(window_px[0]) + int'(window_px[2]) + int'(top) + int'(pix);
				edges = int'(window_px[1]) + int'(window_px[3]) + int'(window_px[5])
					+ int'(mid_row);
				res.pixel_out = filter_pixel(corners, edges, int'(window_px[4]));
				res.last_pixel = 1'b0;
				expected_pixels.push_back(res);
			end
			window_px[0] = window_px[3];
			window_px[1] = window_px[4];
			window_px[2] = window_px[5];
		end
		window_px[3] = top;
		window_px[4] = mid_row;
		window_px[5] = pix;
		if (last_flag) begin
			col_pos = 0;
			row_pos = '0;
		end else if (col_pos + 1 >= len) begin
			col_pos = 0;
			row_pos = row_pos + 17'd1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	always @(posedge clk) begin : sampler
		logic      took_in, took_out, took_cfg;
		out_word_t want;
		took_in = arst_n && in_valid && !in_stall;
		took_out = arst_n && out_valid && !out_stall;
		took_cfg = arst_n && cfg_valid && cfg_ready;
		in_fire <= took_in;
		cfg_fire <= took_cfg;

		// check outputs before predicting, so a stray word cannot match a fresh entry
		if (took_out) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected word: pixel_out %0d last_pixel %0b",
					out_data.pixel_out, out_data.last_pixel);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_data.pixel_out !== want.pixel_out) begin
					$error("pixel_out expected %0d got %0d", want.pixel_out, out_data.pixel_out);
					mismatches++;
				end
				if (out_data.last_pixel !== want.last_pixel) begin
					$error("last_pixel expected %0b got %0b", want.last_pixel,
						out_data.last_pixel);
					mismatches++;
				end
			end
		end

		if (took_in) begin
			absorb_word(in_data);
			words_taken <= words_taken + 1;
		end

		if (took_cfg) begin
			case (reg_index_t'(cfg_index))
				REG_FILTER_KIND:  mode_kind = cfg_data[2:0];
				REG_MAX_VALUE:    mode_max = cfg_data;
				REG_IMAGE_WIDTH:  mode_width = cfg_data[10:0];
				REG_IMAGE_HEIGHT: mode_height = cfg_data;
				default: ;
			endcase
		end

		if (took_in || took_out || took_cfg) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// sender: a word stays put until it is taken
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pixel_queue.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
				in_valid <= 1'b1;
				in_data <= pixel_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done && expected_pixels.size() > 4) begin
			// long back-pressure: the pipeline fills and must stall its input
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 27);
		end
	end

	task automatic push_word(input logic cmd, input logic [15:0] pix);
		in_word_t w;
		w.command = cmd;
		w.pixel_in = pix;
		pixel_queue.push_back(w);
		words_queued++;
	endtask

	task automatic queue_flush(input int len);
		for (int i = 0; i <= len; i++)
			push_word(1'b1, 16'($urandom_range(16'hFFFF)));
	endtask

	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(16'hFFFF));
			default: return 16'($urandom_range(255));
		endcase
	endfunction

	// noisy images mix flush slots into the pixels and pixels into the flush slots
	task automatic queue_image(input int len, input int rows, input logic noisy);
		for (int i = 0; i < len * rows; i++)
			push_word(noisy && ($urandom_range(3) == 0), pick_pixel());
		for (int i = 0; i <= len; i++)
			push_word(!(noisy && ($urandom_range(2) == 0)), 16'($urandom_range(16'hFFFF)));
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(negedge clk);
		while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_all(input logic [15:0] kind, input logic [15:0] maxv,
			input logic [15:0] width, input logic [15:0] height);
		write_reg(REG_FILTER_KIND, kind);
		write_reg(REG_MAX_VALUE, maxv);
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_IMAGE_HEIGHT, height);
	endtask

	// wait until every queued word is taken and every predicted result has come out, then give the pipeline more time
	task automatic settle();
		while (words_taken != words_queued || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int          img_w, img_h, first, random_words;
		logic [15:0] val;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// emboss, full range, a flush slot inside the image
		program_all(KIND_EMBOSS, 16'hFFFF, 16'd3, 16'd2);
		push_word(1'b0, 16'hFFFF);
		push_word(1'b0, 16'h0000);
		push_word(1'b0, 16'hFFFF);
		push_word(1'b1, 16'hA5A5);
		push_word(1'b0, 16'h5A5A);
		push_word(1'b0, 16'hFFFF);
		queue_flush(3);
		settle();

		// unknown kind acts as smooth, width zero acts as one
		program_all(16'd7, 16'd255, 16'd0, 16'd1);
		push_word(1'b0, 16'hFFFF);
		queue_flush(1);
		settle();

		// sharpen clamped to zero
		program_all(KIND_SHARPEN, 16'd0, 16'd2, 16'd2);
		push_word(1'b0, 16'hFFFF);
		push_word(1'b0, 16'h0001);
		push_word(1'b0, 16'h8000);
		push_word(1'b0, 16'h7FFF);
		queue_flush(2);
		settle();

		program_all(KIND_MEAN_REMOVAL, 16'hFFFF, 16'd1, 16'd2);
		push_word(1'b0, 16'h0000);
		push_word(1'b0, 16'hFFFF);
		queue_flush(1);
		settle();

		img_w = 1;
		img_h = 2;
		random_words = 0;
		while (random_words < 300) begin
			if ($urandom_range(3) != 0)
				write_reg(REG_FILTER_KIND, 16'($urandom_range(7)));
			if ($urandom_range(3) != 0) begin
				case ($urandom_range(3))
					0:       val = 16'hFFFF;
					1:       val = 16'd255;
					2:       val = 16'($urandom_range(16'hFFFF));
					default: val = 16'($urandom_range(40));
				endcase
				write_reg(REG_MAX_VALUE, val);
			end
			if ($urandom_range(3) != 0) begin
				img_w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
				write_reg(REG_IMAGE_WIDTH, 16'(img_w));
			end
			if ($urandom_range(3) != 0) begin
				img_h = $urandom_range(1, 6);
				write_reg(REG_IMAGE_HEIGHT, 16'(img_h));
			end
			first = words_queued;
			repeat ($urandom_range(1, 3))
				queue_image(line_len(11'(img_w)), img_h, $urandom_range(4) == 0);
			random_words += words_queued - first;
			settle();
		end

		// receiver holds off while the sender keeps offering
		program_all(KIND_SHARPEN, 16'hFFFF, 16'd16, 16'd4);
		hold_arm <= 1'b1;
		queue_image(16, 4, 1'b0);
		settle();
		hold_arm <= 1'b0;

		// no idling on either side
		program_all(KIND_BLUR, 16'd255, 16'd16, 16'd4);
		no_idle <= 1'b1;
		queue_image(16, 4, 1'b0);
		settle();
		no_idle <= 1'b0;

		// height zero: never a last flag, the stream stays open
		program_all(16'($urandom_range(4)), 16'd255, 16'd5, 16'd0);
		queue_image(5, 8, 1'b1);
		settle();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/pk3c_pkg.sv
rtl/pk3c_line_mem.sv
rtl/pk3c_arith.sv
rtl/preset_kernel_3x3_convolution.sv
sim/tb.sv
